// ===== hw/rtl/ppf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppf_pkg: shared types and constants of the pedal plausibility filter
// Holds the payload structs, the sequencing control group, the register
// index codes and the fixed-point constants that all modules share.
// ----------------------------------------------------------------------------
package ppf_pkg;

   // Width of one raw ADC sample and of the calibration registers.
   localparam int ADC_BITS = 10;

   // Q1.15 fractions run 0..32768, so they need 16 bits.
   localparam int FRAC_BITS = 15;
   localparam int Q_W       = FRAC_BITS + 1;
   localparam logic [Q_W-1:0] ONE_Q15    = Q_W'(32768);
   localparam logic [Q_W-1:0] WEIGHT_MIN = Q_W'(328);

   // Serial step counts: one quotient bit or one multiplier bit per cycle.
   localparam int DIV_STEPS = FRAC_BITS;
   localparam int MUL_STEPS = Q_W;
   localparam int CNT_W     = $clog2(MUL_STEPS);

   // Accumulator of the filter sum; the sum never exceeds 2^30.
   localparam int ACC_W = 2 * FRAC_BITS + 1;

   // Configuration bus.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_FIRST_MIN    = 3'd0,
      REG_FIRST_MAX    = 3'd1,
      REG_SECOND_MIN   = 3'd2,
      REG_SECOND_MAX   = 3'd3,
      REG_SECOND_PRES  = 3'd4,
      REG_SECOND_INV   = 3'd5,
      REG_MAX_DISAGREE = 3'd6,
      REG_SMOOTH_WT    = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [ADC_BITS-1:0] first_raw;
      logic [ADC_BITS-1:0] second_raw;
   } req_type;

   typedef struct packed {
      logic [Q_W-1:0] throttle_fraction;
      logic           fault;
   } rsp_type;

   // Load captures new operands, step advances a serial unit by one bit.
   typedef struct packed {
      logic load;
      logic step;
   } seq_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/dual_sensor_pedal_plausibility_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dual_sensor_pedal_plausibility_filter: redundant pedal sensor check + EMA
// A new request is taken only while the sequencer is idle, after the 15-step
// serial dividers and the 16-step serial multiply-accumulate have run in
// turn for the previous one and its result has been committed.
// Reset (synchronous, active high) restores the register defaults, clears
// the filter level to zero and empties the result register.
// ----------------------------------------------------------------------------
//
// A request transfer loads both sample readings into two bit-serial
// dividers that normalize them against their calibration in parallel, one
// quotient bit per cycle. A combine step then applies the inversion of
// the second sensor, the plausibility check and the averaging, and loads
// the serial multiply-accumulate with the request, the clamped weight and
// the current filter level. After its sixteen steps the new level is
// committed to the state register and copied into the result register.
// If an earlier result is still waiting to be taken, the sequencer holds
// until that transfer happens. The request side is accepted again as soon
// as the sequencer is idle, even while the result register is occupied.
module dual_sensor_pedal_plausibility_filter
   import ppf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   // Result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   // Configuration port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_DIVIDE  = 5'b00010,
      ST_COMBINE = 5'b00100,
      ST_MAC     = 5'b01000,
      ST_COMMIT  = 5'b10000
   } state_type;

   // Configuration registers.
   logic [ADC_BITS-1:0] first_min_ff, first_max_ff;
   logic [ADC_BITS-1:0] second_min_ff, second_max_ff;
   logic                second_present_ff, second_inverted_ff;
   logic [Q_W-1:0]      max_disagree_ff, smooth_weight_ff;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [Q_W-1:0]      level_ff, level_in;
   logic                fault_ff, fault_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   seq_ctl_type         div_ctl, mac_ctl;
   logic [Q_W-1:0]      q_first, q_second, q_second_adj;
   logic [Q_W-1:0]      diff, request, mac_result;
   logic [Q_W:0]        pair_sum;
   logic                disagree;
   logic                req_xfer, rsp_xfer, csr_write, rsp_free;
   reg_idx_type         csr_idx;

   // -------------------------------------------------------------------------
   // Configuration port. Writes complete in the access phase; pready is tied
   // high so there are never wait states.
   // -------------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_idx   = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         first_min_ff       <= '0;
         first_max_ff       <= '1;
         second_min_ff      <= '0;
         second_max_ff      <= '1;
         second_present_ff  <= 1'b0;
         second_inverted_ff <= 1'b0;
         max_disagree_ff    <= Q_W'(3277);
         smooth_weight_ff   <= ONE_Q15;
      end else if (csr_write) begin
         unique case (csr_idx)
            REG_FIRST_MIN:    first_min_ff       <= pwdata[ADC_BITS-1:0];
            REG_FIRST_MAX:    first_max_ff       <= pwdata[ADC_BITS-1:0];
            REG_SECOND_MIN:   second_min_ff      <= pwdata[ADC_BITS-1:0];
            REG_SECOND_MAX:   second_max_ff      <= pwdata[ADC_BITS-1:0];
            REG_SECOND_PRES:  second_present_ff  <= pwdata[0];
            REG_SECOND_INV:   second_inverted_ff <= pwdata[0];
            REG_MAX_DISAGREE: max_disagree_ff    <= pwdata[Q_W-1:0];
            REG_SMOOTH_WT:    smooth_weight_ff   <= pwdata[Q_W-1:0];
            default: ;
         endcase
      end
   end

   // Read data is the register value, zero extended to the bus width.
   always_comb begin
      unique case (csr_idx)
         REG_FIRST_MIN:    prdata = CSR_DATA_W'(first_min_ff);
         REG_FIRST_MAX:    prdata = CSR_DATA_W'(first_max_ff);
         REG_SECOND_MIN:   prdata = CSR_DATA_W'(second_min_ff);
         REG_SECOND_MAX:   prdata = CSR_DATA_W'(second_max_ff);
         REG_SECOND_PRES:  prdata = CSR_DATA_W'(second_present_ff);
         REG_SECOND_INV:   prdata = CSR_DATA_W'(second_inverted_ff);
         REG_MAX_DISAGREE: prdata = CSR_DATA_W'(max_disagree_ff);
         REG_SMOOTH_WT:    prdata = CSR_DATA_W'(smooth_weight_ff);
         default:          prdata = '0;
      endcase
   end

   // -------------------------------------------------------------------------
   // Serial datapath units.
   // -------------------------------------------------------------------------
   assign div_ctl.load = req_xfer;
   assign div_ctl.step = state_ff == ST_DIVIDE;
   assign mac_ctl.load = state_ff == ST_COMBINE;
   assign mac_ctl.step = state_ff == ST_MAC;

   ppf_div u_div_first (
      .clock    (clock),
      .ctl      (div_ctl),
      .raw      (req_data.first_raw),
      .lo       (first_min_ff),
      .hi       (first_max_ff),
      .quotient (q_first)
   );

   ppf_div u_div_second (
      .clock    (clock),
      .ctl      (div_ctl),
      .raw      (req_data.second_raw),
      .lo       (second_min_ff),
      .hi       (second_max_ff),
      .quotient (q_second)
   );

   // Combine step: an inverted second sensor reads 1.0 minus its fraction.
   // The sensors disagree when the absolute difference is strictly above the
   // limit; then the request drops to zero, otherwise it is the mean. With
   // the second sensor absent the first fraction is used alone.
   always_comb begin
      q_second_adj = second_inverted_ff ? ONE_Q15 - q_second : q_second;
      diff         = (q_first > q_second_adj) ? q_first - q_second_adj
                                              : q_second_adj - q_first;
      pair_sum     = {1'b0, q_first} + {1'b0, q_second_adj};
      disagree     = second_present_ff && (diff > max_disagree_ff);
      if (!second_present_ff) begin
         request = q_first;
      end else if (disagree) begin
         request = '0;
      end else begin
         request = pair_sum[Q_W:1];
      end
   end

   ppf_mac u_mac (
      .clock   (clock),
      .ctl     (mac_ctl),
      .weight  (smooth_weight_ff),
      .request (request),
      .level   (level_ff),
      .result  (mac_result)
   );

   // -------------------------------------------------------------------------
   // Sequencer and result register.
   // -------------------------------------------------------------------------
   assign req_stall = state_ff != ST_IDLE;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      level_in     = level_ff;
      fault_in     = fault_ff;
      rsp_valid_in = rsp_xfer ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_DIVIDE;
               cnt_in   = CNT_W'(DIV_STEPS - 1);
            end
         end
         ST_DIVIDE: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_COMBINE;
            end
         end
         ST_COMBINE: begin
            fault_in = disagree;
            state_in = ST_MAC;
            cnt_in   = CNT_W'(MUL_STEPS - 1);
         end
         ST_MAC: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (rsp_free) begin
               level_in                      = mac_result;
               rsp_valid_in                  = 1'b1;
               rsp_data_in.throttle_fraction = mac_result;
               rsp_data_in.fault             = fault_ff;
               state_in                      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fault_ff    <= fault_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ppf_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppf_div: bit-serial normalizing divider
// Computes ((raw - lo) << 15) / (hi - lo) one quotient bit per step, with
// the clamp to 0..32768 and the degenerate calibration case folded in.
// ----------------------------------------------------------------------------
module ppf_div
   import ppf_pkg::*;
(
   input  wire logic                clock,
   input  wire seq_ctl_type         ctl,
   input  wire logic [ADC_BITS-1:0] raw,
   input  wire logic [ADC_BITS-1:0] lo,
   input  wire logic [ADC_BITS-1:0] hi,
   output logic      [Q_W-1:0]      quotient
);

   logic [ADC_BITS-1:0]  rem_ff, rem_in;
   logic [ADC_BITS-1:0]  den_ff, den_in;
   logic [FRAC_BITS-1:0] q_ff, q_in;
   logic                 zero_ff, zero_in;
   logic                 full_ff, full_in;
   logic [ADC_BITS:0]    rem_dbl;
   logic                 fits;

   // When raw >= hi and hi > lo the true quotient is at least 1.0 and clamps there;
   // otherwise raw - lo < hi - lo and the remainder stays below the divisor.
   always_comb begin
      rem_dbl = {rem_ff, 1'b0};
      fits    = rem_dbl >= {1'b0, den_ff};
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      zero_in = zero_ff;
      full_in = full_ff;
      if (ctl.load) begin
         rem_in  = raw - lo;
         den_in  = hi - lo;
         q_in    = '0;
         zero_in = (hi <= lo) || (raw <= lo);
         full_in = raw >= hi;
      end else if (ctl.step) begin
         rem_in = fits ? ADC_BITS'(rem_dbl - {1'b0, den_ff}) : rem_dbl[ADC_BITS-1:0];
         q_in   = {q_ff[FRAC_BITS-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      zero_ff <= zero_in;
      full_ff <= full_in;
   end

   always_comb begin
      if (zero_ff) begin
         quotient = '0;
      end else if (full_ff) begin
         quotient = ONE_Q15;
      end else begin
         quotient = {1'b0, q_ff};
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ppf_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppf_mac: bit-serial filter multiply-accumulate
// Forms a*req + (32768-a)*level one multiplier bit per step, most
// significant bit first, and returns the sum shifted down by 15.
// ----------------------------------------------------------------------------
module ppf_mac
   import ppf_pkg::*;
(
   input  wire logic           clock,
   input  wire seq_ctl_type    ctl,
   input  wire logic [Q_W-1:0] weight,
   input  wire logic [Q_W-1:0] request,
   input  wire logic [Q_W-1:0] level,
   output logic      [Q_W-1:0] result
);

   logic [Q_W-1:0]   wa_ff, wa_in;
   logic [Q_W-1:0]   wb_ff, wb_in;
   logic [Q_W-1:0]   req_sr_ff, req_sr_in;
   logic [Q_W-1:0]   lev_sr_ff, lev_sr_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [Q_W-1:0]   wclamp;
   logic [Q_W-1:0]   addend;

   always_comb begin
      if (weight < WEIGHT_MIN) begin
         wclamp = WEIGHT_MIN;
      end else if (weight > ONE_Q15) begin
         wclamp = ONE_Q15;
      end else begin
         wclamp = weight;
      end
   end

   // Both bits set contributes a + (32768 - a), which is 32768 exactly.
   always_comb begin
      case ({req_sr_ff[Q_W-1], lev_sr_ff[Q_W-1]})
         2'b10:   addend = wa_ff;
         2'b01:   addend = wb_ff;
         2'b11:   addend = ONE_Q15;
         default: addend = '0;
      endcase
   end

   always_comb begin
      wa_in     = wa_ff;
      wb_in     = wb_ff;
      req_sr_in = req_sr_ff;
      lev_sr_in = lev_sr_ff;
      acc_in    = acc_ff;
      if (ctl.load) begin
         wa_in     = wclamp;
         wb_in     = ONE_Q15 - wclamp;
         req_sr_in = request;
         lev_sr_in = level;
         acc_in    = '0;
      end else if (ctl.step) begin
         req_sr_in = {req_sr_ff[Q_W-2:0], 1'b0};
         lev_sr_in = {lev_sr_ff[Q_W-2:0], 1'b0};
         acc_in    = {acc_ff[ACC_W-2:0], 1'b0} + ACC_W'(addend);
      end
   end

   always_ff @(posedge clock) begin
      wa_ff     <= wa_in;
      wb_ff     <= wb_in;
      req_sr_ff <= req_sr_in;
      lev_sr_ff <= lev_sr_in;
      acc_ff    <= acc_in;
   end

   assign result = acc_ff[ACC_W-1:FRAC_BITS];

endmodule

`default_nettype wire

// ===== tb/sv/pedal_filter_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pedal_filter_checker: result checker for the pedal plausibility filter
// Watches register writes, request transfers and result transfers. It keeps
// its own copy of the settings and of the filter level, predicts each result
// and compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module pedal_filter_checker
   import ppf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire req_type               req_data,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire rsp_type               rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic                  pready,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output int                         mismatch_count,
   output int                         pending_count,
   output int                         results_checked,
   output int                         faults_seen
);

   localparam int PRINT_CAP = 200;

   logic [ADC_BITS-1:0] first_lo, first_hi, second_lo, second_hi;
   logic                second_fitted, second_flipped;
   logic [Q_W-1:0]      agree_limit, new_weight, level;
   rsp_type             awaited_levels[$];

   task report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) $display("%0t ns  mismatch: %s", $time, what);
   endtask

   function automatic logic [Q_W-1:0] normalize_raw(input logic [ADC_BITS-1:0] raw,
                                                    input logic [ADC_BITS-1:0] lo,
                                                    input logic [ADC_BITS-1:0] hi);
      logic [31:0] quotient;
      if (hi <= lo || raw <= lo) return '0;
      quotient = (32'(raw - lo) << FRAC_BITS) / 32'(hi - lo);
      return (quotient > 32'(ONE_Q15)) ? ONE_Q15 : quotient[Q_W-1:0];
   endfunction

   // Plausibility check, averaging and one step of the exponential filter.
   function automatic rsp_type predict_throttle(input req_type pair);
      logic [Q_W-1:0] frac_a, frac_b, spread, weight;
      logic [Q_W:0]   demand;
      logic [47:0]    blend;
      rsp_type        outcome;
      frac_a = normalize_raw(pair.first_raw, first_lo, first_hi);
      demand = {1'b0, frac_a};
      outcome.fault = 1'b0;
      if (second_fitted) begin
         frac_b = normalize_raw(pair.second_raw, second_lo, second_hi);
         if (second_flipped) frac_b = ONE_Q15 - frac_b;
         spread = (frac_a > frac_b) ? frac_a - frac_b : frac_b - frac_a;
         if (spread > agree_limit) begin
            outcome.fault = 1'b1;
            demand = '0;
         end else begin
            demand = ({1'b0, frac_a} + {1'b0, frac_b}) >> 1;
         end
      end
      weight = (new_weight < WEIGHT_MIN) ? WEIGHT_MIN :
               (new_weight > ONE_Q15) ? ONE_Q15 : new_weight;
      blend = 48'(weight) * 48'(demand) + 48'(ONE_Q15 - weight) * 48'(level);
      outcome.throttle_fraction = blend[FRAC_BITS +: Q_W];
      return outcome;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type wanted;
      if (reset) begin
         first_lo       = '0;
         first_hi       = 10'd1023;
         second_lo      = '0;
         second_hi      = 10'd1023;
         second_fitted  = 1'b0;
         second_flipped = 1'b0;
         agree_limit    = 16'd3277;
         new_weight     = ONE_Q15;
         level          = '0;
         awaited_levels.delete();
         pending_count <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_idx_type'(paddr[CSR_ADDR_W-1:2]))
               REG_FIRST_MIN:    first_lo       = pwdata[ADC_BITS-1:0];
               REG_FIRST_MAX:    first_hi       = pwdata[ADC_BITS-1:0];
               REG_SECOND_MIN:   second_lo      = pwdata[ADC_BITS-1:0];
               REG_SECOND_MAX:   second_hi      = pwdata[ADC_BITS-1:0];
               REG_SECOND_PRES:  second_fitted  = pwdata[0];
               REG_SECOND_INV:   second_flipped = pwdata[0];
               REG_MAX_DISAGREE: agree_limit    = pwdata[Q_W-1:0];
               REG_SMOOTH_WT:    new_weight     = pwdata[Q_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            wanted = predict_throttle(req_data);
            level  = wanted.throttle_fraction;
            awaited_levels.push_back(wanted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_levels.size() == 0) begin
               report_mismatch($sformatf("result %h arrived with nothing expected", rsp_data));
            end else begin
               wanted = awaited_levels.pop_front();
               results_checked++;
               if (wanted.fault) faults_seen++;
               if (rsp_data.throttle_fraction !== wanted.throttle_fraction)
                  report_mismatch($sformatf("throttle_fraction %0d, expected %0d",
                                            rsp_data.throttle_fraction,
                                            wanted.throttle_fraction));
               if (rsp_data.fault !== wanted.fault)
                  report_mismatch($sformatf("fault %b, expected %b",
                                            rsp_data.fault, wanted.fault));
            end
         end
         pending_count <= awaited_levels.size();
      end
   end

endmodule

// ===== tb/sv/tb_dual_sensor_pedal_plausibility_filter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_sensor_pedal_plausibility_filter: testbench of the pedal filter
// Drives sample pairs and register settings into the block, with random
// gaps on the request side and random stalls on the result side. A checker
// beside the block predicts every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_dual_sensor_pedal_plausibility_filter
   import ppf_pkg::*;
();

   // Even with every gap and stall at its longest, a correct run of all the
   // sample pairs stays far below this limit.
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 40;
   localparam int TOTAL_PAIRS   = 1350;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int mismatch_count, pending_count, results_checked, faults_seen;
   int pairs_sent    = 0;
   int settings_used = 1;
   int cycle_count   = 0;

   // Set once by the stimulus; the result side then holds off for a long
   // stretch so that the block fills up and stalls its request side.
   logic hold_request   = 1'b0;
   bit   sender_unpaced = 1'b0;

   // Settings as last written, used to aim the samples at interesting spots.
   logic [ADC_BITS-1:0] cal_first_lo  = '0;
   logic [ADC_BITS-1:0] cal_first_hi  = 10'd1023;
   logic [ADC_BITS-1:0] cal_second_lo = '0;
   logic [ADC_BITS-1:0] cal_second_hi = 10'd1023;
   logic                cal_flipped   = 1'b0;

   dual_sensor_pedal_plausibility_filter u_top (.*);

   pedal_filter_checker u_checker (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still outstanding.",
                  cycle_count, pending_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Most gaps are short, a few are long.
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(60, 15);
   endfunction

   // Mostly a sane span, sometimes the full range, sometimes degenerate
   // (max at or below min).
   function automatic void pick_calibration(output logic [ADC_BITS-1:0] lo,
                                            output logic [ADC_BITS-1:0] hi);
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 10) begin
         hi = ADC_BITS'($urandom_range(1023, 0));
         lo = ADC_BITS'($urandom_range(1023, int'(hi)));
      end else if (roll < 25) begin
         lo = '0;
         hi = 10'd1023;
      end else begin
         lo = ADC_BITS'($urandom_range(400, 0));
         hi = ADC_BITS'($urandom_range(1023, int'(lo) + 1));
      end
   endfunction

   // Random upper bits ride along above each register value; the block
   // keeps only the bits that belong to the register.
   function automatic logic [CSR_DATA_W-1:0] with_noise(input logic [CSR_DATA_W-1:0] value,
                                                        input int width);
      logic [CSR_DATA_W-1:0] keep;
      keep = (32'd1 << width) - 32'd1;
      return ($urandom() & ~keep) | (value & keep);
   endfunction

   // One write transfer: setup cycle, then access cycle until pready. The
   // select stays up so that writes run back to back; the caller drops it.
   task automatic write_register(input reg_idx_type idx, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   task automatic apply_settings(input logic [ADC_BITS-1:0] first_lo,
                                 input logic [ADC_BITS-1:0] first_hi,
                                 input logic [ADC_BITS-1:0] second_lo,
                                 input logic [ADC_BITS-1:0] second_hi,
                                 input logic fitted, input logic flipped,
                                 input logic [Q_W-1:0] limit, input logic [Q_W-1:0] weight);
      write_register(REG_FIRST_MIN,    with_noise(32'(first_lo), ADC_BITS));
      write_register(REG_FIRST_MAX,    with_noise(32'(first_hi), ADC_BITS));
      write_register(REG_SECOND_MIN,   with_noise(32'(second_lo), ADC_BITS));
      write_register(REG_SECOND_MAX,   with_noise(32'(second_hi), ADC_BITS));
      write_register(REG_SECOND_PRES,  with_noise(32'(fitted), 1));
      write_register(REG_SECOND_INV,   with_noise(32'(flipped), 1));
      write_register(REG_MAX_DISAGREE, with_noise(32'(limit), Q_W));
      write_register(REG_SMOOTH_WT,    with_noise(32'(weight), Q_W));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cal_first_lo  = first_lo;
      cal_first_hi  = first_hi;
      cal_second_lo = second_lo;
      cal_second_hi = second_hi;
      cal_flipped   = flipped;
      settings_used++;
   endtask

   // Offer one sample pair and wait for its transfer. Valid stays high into
   // the next call when no gap follows.
   task automatic send_sample(input logic [ADC_BITS-1:0] raw_a, input logic [ADC_BITS-1:0] raw_b);
      int gap;
      gap = sender_unpaced ? 0 : gap_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{first_raw: raw_a, second_raw: raw_b};
      do @(posedge clock); while (req_stall);
      pairs_sent++;
   endtask

   // Stop offering and wait until every predicted result has been taken.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Result side: random stalls, some stretches with none at all, and a
   // single long hold-off when the stimulus asks for it.
   initial begin : result_receiver
      int span;
      bit hold_served;
      hold_served = 1'b0;
      wait (!reset);
      forever begin
         if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if ($urandom_range(99, 0) < 6) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(120, 40)) @(posedge clock);
         end else begin
            span = gap_length();
            rsp_stall <= (span != 0);
            repeat ((span == 0) ? 1 : span) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int                  phase, burst, roll, span_a, span_b, target;
      logic [ADC_BITS-1:0] lo_a, hi_a, lo_b, hi_b, raw_a, raw_b;
      logic                fitted;
      logic [Q_W-1:0]      limit, weight;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Settings as left by reset: the first sensor alone over the full span
      // and no smoothing. The second reading must not matter here.
      send_sample(10'd0, 10'd1023);
      send_sample(10'd1023, 10'd0);
      send_sample(10'd512, 10'd341);
      send_sample(10'd1, 10'd682);
      drain_results();

      // Both sensors over 0..512, so a fraction is 64 per count. A spread of
      // exactly the limit still agrees, one more count faults; readings
      // above the calibrated max clamp to full scale.
      apply_settings(10'd0, 10'd512, 10'd0, 10'd512, 1'b1, 1'b0, 16'd64, ONE_Q15);
      send_sample(10'd100, 10'd101);
      send_sample(10'd100, 10'd102);
      send_sample(10'd600, 10'd700);
      send_sample(10'd0, 10'd0);
      send_sample(10'd512, 10'd511);
      drain_results();

      // Inverted second sensor with zero tolerance, and a weight of zero
      // that must act as the minimum weight.
      apply_settings(10'd0, 10'd512, 10'd0, 10'd512, 1'b1, 1'b1, 16'd0, 16'd0);
      send_sample(10'd256, 10'd256);
      send_sample(10'd0, 10'd512);
      send_sample(10'd1023, 10'd0);
      send_sample(10'd300, 10'd300);
      drain_results();

      // Degenerate calibrations: max equal to min on the first sensor, max
      // below min on the second. Widest tolerance, weight above full scale.
      apply_settings(10'd700, 10'd700, 10'd900, 10'd200, 1'b1, 1'b0, ONE_Q15, 16'hFFFF);
      send_sample(10'd700, 10'd900);
      send_sample(10'd1023, 10'd1023);
      send_sample(10'd0, 10'd0);
      drain_results();

      // Full span on both, tolerance at the register's top, weight exactly
      // at the minimum so the level creeps.
      apply_settings(10'd0, 10'd1023, 10'd0, 10'd1023, 1'b1, 1'b0, 16'hFFFF, WEIGHT_MIN);
      send_sample(10'd1023, 10'd0);
      send_sample(10'd0, 10'd1023);
      send_sample(10'd1023, 10'd1023);
      drain_results();

      // Random phases: fresh settings each time, then a burst of pairs in
      // which most second readings track the first through both
      // calibrations, so that agreement is common and faults still occur.
      phase = 0;
      while (pairs_sent < TOTAL_PAIRS) begin
         pick_calibration(lo_a, hi_a);
         if ($urandom_range(1, 0) == 0) begin
            lo_b = lo_a;
            hi_b = hi_a;
         end else begin
            pick_calibration(lo_b, hi_b);
         end
         fitted = ($urandom_range(99, 0) < 85);
         case ($urandom_range(4, 0))
            0:       limit = '0;
            1:       limit = ONE_Q15;
            2:       limit = 16'hFFFF;
            3:       limit = Q_W'($urandom_range(4000, 0));
            default: limit = Q_W'($urandom_range(65535, 0));
         endcase
         case ($urandom_range(7, 0))
            0:       weight = '0;
            1:       weight = WEIGHT_MIN - 16'd1;
            2:       weight = WEIGHT_MIN;
            3:       weight = ONE_Q15;
            4:       weight = ONE_Q15 + 16'd1;
            5:       weight = 16'hFFFF;
            default: weight = Q_W'($urandom_range(32768, 328));
         endcase
         apply_settings(lo_a, hi_a, lo_b, hi_b, fitted, 1'($urandom_range(1, 0)), limit,
                        weight);

         if (phase == 2) hold_request <= 1'b1;
         sender_unpaced = ($urandom_range(3, 0) == 0);
         burst = $urandom_range(125, 90);
         if (burst > TOTAL_PAIRS - pairs_sent) burst = TOTAL_PAIRS - pairs_sent;
         span_a = int'(cal_first_hi) - int'(cal_first_lo);
         span_b = int'(cal_second_hi) - int'(cal_second_lo);

         repeat (burst) begin
            roll = $urandom_range(99, 0);
            if (roll < 15) begin
               case ($urandom_range(3, 0))
                  0:       raw_a = '0;
                  1:       raw_a = 10'd1023;
                  2:       raw_a = cal_first_lo;
                  default: raw_a = cal_first_hi;
               endcase
            end else begin
               raw_a = ADC_BITS'($urandom_range(1023, 0));
            end
            if ($urandom_range(99, 0) < 70 && span_a > 0 && span_b > 0) begin
               target = (int'(raw_a) - int'(cal_first_lo)) * span_b / span_a;
               target = cal_flipped ? int'(cal_second_hi) - target
                                    : int'(cal_second_lo) + target;
               target = target + int'($urandom_range(12, 0)) - 6;
               raw_b = (target < 0) ? '0 : (target > 1023) ? 10'd1023 : ADC_BITS'(target);
            end else begin
               raw_b = ADC_BITS'($urandom_range(1023, 0));
            end
            send_sample(raw_a, raw_b);
         end
         drain_results();
         phase++;
      end

      // Give a stray extra result the time to show up before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d sample pairs under %0d register settings, one long hold-off.",
               pairs_sent, settings_used);
      $display("%0d results checked, %0d with the disagreement fault; %0d mismatches.",
               results_checked, faults_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
